### src/quality_longest_run_trimmer_defines.svh
// Assertion macros used by the run tracker of the quality run trimmer RTL.
`ifndef QUALITY_LONGEST_RUN_TRIMMER_DEFINES_SVH
`define QUALITY_LONGEST_RUN_TRIMMER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition implies consequence in the same cycle.
`define QLRT_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
		else $error("qlrt assertion failed");
// Condition implies consequence in the next cycle.
`define QLRT_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("qlrt assertion failed");
`else
`define QLRT_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define QLRT_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

### src/qlrt_pkg.sv
// Types and constants shared by the quality run trimmer modules.
`timescale 1ns / 1ps
package qlrt_pkg;

	localparam int OUT_W = 16;
	localparam int QUAL_W = 8;
	localparam int CFG_Q_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PHRED_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUALITY_CUTOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd2;

	// Reset values: sanger offset, cutoff 20, no minimum
	localparam logic [CFG_Q_W-1:0] PHRED_OFFSET_RST = 7'd33;
	localparam logic [CFG_Q_W-1:0] QUALITY_CUTOFF_RST = 7'd20;
	localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RST = 16'd0;

	typedef struct packed {
		logic [CFG_Q_W-1:0]    phred_offset;
		logic [CFG_Q_W-1:0]    quality_cutoff;
		logic [CFG_DATA_W-1:0] min_length;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] trim_start;
		logic [OUT_W-1:0] trim_end;
		logic [OUT_W-1:0] run_length;
		logic             is_long;
	} result_t;

endpackage

### src/qlrt_cfg.sv
// Configuration register file of the quality run trimmer.
`timescale 1ns / 1ps
module qlrt_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qlrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qlrt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output qlrt_pkg::cfg_t                      cfg
);
	import qlrt_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phred_offset <= PHRED_OFFSET_RST;
			cfg_q.quality_cutoff <= QUALITY_CUTOFF_RST;
			cfg_q.min_length <= MIN_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHRED_OFFSET: begin
					cfg_q.phred_offset <= cfg_wdata[CFG_Q_W-1:0];
				end
				REG_QUALITY_CUTOFF: begin
					cfg_q.quality_cutoff <= cfg_wdata[CFG_Q_W-1:0];
				end
				REG_MIN_LENGTH: begin
					cfg_q.min_length <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/qlrt_tracker.sv
// Per-read run tracker: qualify test, run counters and result formation.
`timescale 1ns / 1ps
`include "quality_longest_run_trimmer_defines.svh"
module qlrt_tracker #(
	parameter int MAX_READ_LEN = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [qlrt_pkg::QUAL_W-1:0]     qual_byte,
	input  logic                            last,
	input  qlrt_pkg::cfg_t                  cfg,
	output qlrt_pkg::result_t               result
);
	import qlrt_pkg::*;

	localparam int POS_W = $clog2(MAX_READ_LEN + 1);
	localparam int EXT_W = (POS_W > OUT_W) ? POS_W : OUT_W;
	localparam int THR_W = QUAL_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_READ_LEN);

	logic [POS_W-1:0] position_q, cur_start_q, cur_len_q, best_start_q, best_len_q;
	logic [POS_W-1:0] position_n, cur_start_n, cur_len_n, best_start_n, best_len_n;
	logic [THR_W-1:0] threshold;
	logic             good;
	logic [EXT_W-1:0] start_ext, len_ext, end_ext, min_ext;

	// Qualify test without wrap: q >= offset + cutoff
	assign threshold = {2'b00, cfg.phred_offset} + {2'b00, cfg.quality_cutoff};
	assign good = {1'b0, qual_byte} >= threshold;

	// Next run state; bytes past the saturation point change nothing
	always_comb begin
		position_n = position_q;
		cur_start_n = cur_start_q;
		cur_len_n = cur_len_q;
		best_start_n = best_start_q;
		best_len_n = best_len_q;
		if (position_q < POS_MAX) begin
			if (good) begin
				if (cur_len_q == '0) begin
					cur_start_n = position_q;
				end
				cur_len_n = cur_len_q + 1'b1;
				// strict compare keeps the first of equal runs
				if (cur_len_n > best_len_q) begin
					best_start_n = cur_start_n;
					best_len_n = cur_len_n;
				end
			end else begin
				cur_len_n = '0;
			end
			position_n = position_q + 1'b1;
		end
	end

	// Result from the state including this byte, cut to 16 bits
	assign start_ext = EXT_W'(best_start_n);
	assign len_ext = EXT_W'(best_len_n);
	assign end_ext = start_ext + len_ext;
	assign min_ext = EXT_W'(cfg.min_length);

	assign result.trim_start = start_ext[OUT_W-1:0];
	assign result.trim_end = end_ext[OUT_W-1:0];
	assign result.run_length = len_ext[OUT_W-1:0];
	assign result.is_long = len_ext >= min_ext;

	// State registers; the last byte clears them for the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			cur_start_q <= '0;
			cur_len_q <= '0;
			best_start_q <= '0;
			best_len_q <= '0;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				cur_start_q <= '0;
				cur_len_q <= '0;
				best_start_q <= '0;
				best_len_q <= '0;
			end else begin
				position_q <= position_n;
				cur_start_q <= cur_start_n;
				cur_len_q <= cur_len_n;
				best_start_q <= best_start_n;
				best_len_q <= best_len_n;
			end
		end
	end

	// Invariants of the run counters
	`QLRT_ASSERT_NOW(a_best_ge_cur, clk, arst_n, 1'b1, best_len_q >= cur_len_q)
	`QLRT_ASSERT_NOW(a_cur_le_pos, clk, arst_n, 1'b1, cur_len_q <= position_q)
	`QLRT_ASSERT_NOW(a_pos_sat, clk, arst_n, 1'b1, position_q <= POS_MAX)
	`QLRT_ASSERT_NEXT(a_last_clears, clk, arst_n, step && last, position_q == '0 && best_len_q == '0)

endmodule

### src/quality_longest_run_trimmer.sv
// Bytes pass the input register; a last byte's result and out_valid are registered together.
// Throughput: one byte per cycle while not stalled; one result per read on the last byte.
// The rate is set by the run counters in qlrt_tracker, whose next state is combinational.
// A result waiting in the output register stalls only a following last byte.
// Reset (arst_n low, asynchronous): per-read state cleared, registers to 33 / 20 / 0.
`timescale 1ns / 1ps
module quality_longest_run_trimmer #(
	parameter int MAX_READ_LEN = 65535
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qlrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qlrt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [qlrt_pkg::QUAL_W-1:0]         qual_byte,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [qlrt_pkg::OUT_W-1:0]          trim_start,
	output logic [qlrt_pkg::OUT_W-1:0]          trim_end,
	output logic [qlrt_pkg::OUT_W-1:0]          run_length,
	output logic                                is_long
);
	import qlrt_pkg::*;

	cfg_t              cfg;
	result_t           result;
	result_t           result_q;
	logic              out_valid_q;
	logic              valid_s1;
	logic [QUAL_W-1:0] qual_s1;
	logic              last_s1;
	logic              advance;

	qlrt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage 1 byte moves on unless it is a last byte and the result slot is full
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			qual_s1 <= qual_byte;
			last_s1 <= last;
		end
	end

	qlrt_tracker #(
		.MAX_READ_LEN (MAX_READ_LEN)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.qual_byte (qual_s1),
		.last      (last_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign trim_start = result_q.trim_start;
	assign trim_end = result_q.trim_end;
	assign run_length = result_q.run_length;
	assign is_long = result_q.is_long;

endmodule
